// ===== hdl/drfc_pkg.sv =====
// Shared types and constants for the DHCP request frame classifier.
`timescale 1ns / 1ps

package drfc_pkg;

	// Byte counter width default
	localparam int DRFC_INDEX_BITS = 7;

	// Configuration port
	localparam int DRFC_CFG_INDEX_BITS = 1;
	localparam int DRFC_CFG_DATA_BITS  = 1;
	localparam logic [DRFC_CFG_INDEX_BITS-1:0] DRFC_REG_CLIENT_MODE      = 1'b0;
	localparam logic [DRFC_CFG_INDEX_BITS-1:0] DRFC_REG_GATEWAY_SELECTED = 1'b1;

	// Frame layout
	localparam int DRFC_POS_TYPE_HI     = 12;
	localparam int DRFC_POS_TYPE_LO     = 13;
	localparam int DRFC_POS_INNER_HI    = 16;
	localparam int DRFC_POS_INNER_LO    = 17;
	localparam int DRFC_IP_START_PLAIN  = 14;
	localparam int DRFC_IP_START_TAGGED = 18;
	localparam int DRFC_IP_PROTO_OFS    = 9;
	localparam int DRFC_UDP_DPORT_OFS   = 2;
	localparam int DRFC_IP_MIN_HDR      = 20;
	localparam int DRFC_UDP_HDR         = 8;

	// Field values
	localparam logic [15:0] DRFC_ETHTYPE_VLAN = 16'h8100;
	localparam logic [15:0] DRFC_ETHTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  DRFC_PROTO_UDP    = 8'd17;
	localparam logic [15:0] DRFC_BOOTP_PORT   = 16'd67;

	// Header fields captured from one frame
	typedef struct packed {
		logic        vlan_tagged;
		logic [15:0] inner_ethertype;
		logic [5:0]  ip_header_bytes;
		logic [7:0]  ip_protocol;
		logic [15:0] udp_dest_port;
	} drfc_frame_t;

endpackage

// ===== hdl/dhcp_request_frame_classifier.sv =====
// Top level of the DHCP request frame classifier.
//
// Usage: frame bytes arrive on the input channel (in_valid / in_stall) in
// wire order, end_of_frame marking the last byte of each frame. One request
// comes out on the output channel (out_valid / out_stall) per frame, on its
// last byte: is_target is 1 for an IPv4 UDP frame to port 67 (one optional
// 802.1Q tag skipped, length checked) while client_mode and gateway_selected
// are both set. Non-final bytes produce no output request.
// Timing: a byte is captured in an input register, then header capture and
// the verdict are combinational into the output register; a last byte
// passes the input, then the output register. One byte is taken per
// cycle while in_stall is low, limited only by the single output register.
// Stalls: while the output register holds an untaken verdict and out_stall
// is high, a last byte waiting in the input register cannot finish, and
// in_stall goes high; other bytes keep flowing.
// Reset: arst_n clears the configuration bits, the frame state, and both
// valid flags. Configuration is written via cfg_we / cfg_index / cfg_data;
// the user must write it only when the block is idle; nothing enforces it.
`timescale 1ns / 1ps

module dhcp_request_frame_classifier #(
	parameter int INDEX_BITS = drfc_pkg::DRFC_INDEX_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [drfc_pkg::DRFC_CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [drfc_pkg::DRFC_CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [7:0]                               frame_byte,
	input  logic                                     end_of_frame,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     is_target
);

	logic                  client_mode_q;
	logic                  gateway_selected_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eof_s1;
	logic                  go;
	logic                  verdict;
	logic                  out_valid_q;
	logic                  is_target_q;
	drfc_pkg::drfc_frame_t frame_nxt;
	logic [INDEX_BITS:0]   byte_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_mode_q      <= 1'b0;
			gateway_selected_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drfc_pkg::DRFC_REG_CLIENT_MODE:      client_mode_q      <= cfg_data[0];
				drfc_pkg::DRFC_REG_GATEWAY_SELECTED: gateway_selected_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1 finishes unless it is a last byte blocked by a held verdict
	assign go       = valid_s1 && (!eof_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= frame_byte;
			eof_s1  <= end_of_frame;
		end
	end

	drfc_fields #(
		.INDEX_BITS(INDEX_BITS)
	) u_fields (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (go),
		.frame_byte  (byte_s1),
		.end_of_frame(eof_s1),
		.frame_nxt   (frame_nxt),
		.byte_count  (byte_count)
	);

	drfc_verdict #(
		.INDEX_BITS(INDEX_BITS)
	) u_verdict (
		.frame           (frame_nxt),
		.byte_count      (byte_count),
		.client_mode     (client_mode_q),
		.gateway_selected(gateway_selected_q),
		.is_target       (verdict)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && eof_s1) begin
			is_target_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_target = is_target_q;

	// A new verdict appears only after a last byte was processed
	a_rise_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go && eof_s1))
		else $error("output request without a processed last byte");

	// Frame position restarts after a last byte
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && eof_s1) |=> (byte_count == (INDEX_BITS + 1)'(1)))
		else $error("byte position not cleared after frame end");

	// A blocked byte in stage 1 is held
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> (valid_s1 && $stable(byte_s1) && $stable(eof_s1)))
		else $error("stage 1 request lost while blocked");

endmodule

// ===== hdl/drfc_fields.sv =====
// Byte position counter and header field capture for one frame.
`timescale 1ns / 1ps

module drfc_fields #(
	parameter int INDEX_BITS = drfc_pkg::DRFC_INDEX_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                frame_byte,
	input  logic                      end_of_frame,
	output drfc_pkg::drfc_frame_t     frame_nxt,
	output logic [INDEX_BITS:0]       byte_count
);

	localparam int IW = INDEX_BITS;

	logic [IW-1:0]         byte_index_q;
	logic [7:0]            outer_hi_q;
	drfc_pkg::drfc_frame_t frame_q;
	logic [7:0]            outer_hi_nxt;
	logic [IW-1:0]         ip_start;
	logic [IW-1:0]         udp_start;
	logic [IW-1:0]         index_nxt;

	// Field capture at fixed and header-relative positions
	always_comb begin
		frame_nxt    = frame_q;
		outer_hi_nxt = outer_hi_q;
		ip_start     = frame_q.vlan_tagged ? IW'(drfc_pkg::DRFC_IP_START_TAGGED)
		                                   : IW'(drfc_pkg::DRFC_IP_START_PLAIN);
		udp_start    = ip_start + IW'(frame_q.ip_header_bytes);

		priority if (byte_index_q == IW'(drfc_pkg::DRFC_POS_TYPE_HI)) begin
			outer_hi_nxt = frame_byte;
		end else if (byte_index_q == IW'(drfc_pkg::DRFC_POS_TYPE_LO)) begin
			frame_nxt.vlan_tagged = ({outer_hi_q, frame_byte} == drfc_pkg::DRFC_ETHTYPE_VLAN);
			if ({outer_hi_q, frame_byte} != drfc_pkg::DRFC_ETHTYPE_VLAN) begin
				frame_nxt.inner_ethertype = {outer_hi_q, frame_byte};
			end
		end else if (frame_q.vlan_tagged
		             && byte_index_q == IW'(drfc_pkg::DRFC_POS_INNER_HI)) begin
			frame_nxt.inner_ethertype[15:8] = frame_byte;
		end else if (frame_q.vlan_tagged
		             && byte_index_q == IW'(drfc_pkg::DRFC_POS_INNER_LO)) begin
			frame_nxt.inner_ethertype[7:0] = frame_byte;
		end else begin
			frame_nxt.inner_ethertype = frame_q.inner_ethertype;
		end

		if (byte_index_q >= IW'(drfc_pkg::DRFC_IP_START_PLAIN)) begin
			if (byte_index_q == ip_start) begin
				frame_nxt.ip_header_bytes = {frame_byte[3:0], 2'b00};
			end
			if (byte_index_q == ip_start + IW'(drfc_pkg::DRFC_IP_PROTO_OFS)) begin
				frame_nxt.ip_protocol = frame_byte;
			end
			// UDP header is never read at the first IP byte
			if (byte_index_q > ip_start
			    && byte_index_q == udp_start + IW'(drfc_pkg::DRFC_UDP_DPORT_OFS)) begin
				frame_nxt.udp_dest_port[15:8] = frame_byte;
			end
			if (byte_index_q > ip_start
			    && byte_index_q == udp_start + IW'(drfc_pkg::DRFC_UDP_DPORT_OFS + 1)) begin
				frame_nxt.udp_dest_port[7:0] = frame_byte;
			end
		end
	end

	// Saturating position counter
	assign index_nxt  = (byte_index_q != {IW{1'b1}}) ? byte_index_q + IW'(1) : byte_index_q;
	assign byte_count = {1'b0, byte_index_q} + (IW + 1)'(1);

	// Frame state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			outer_hi_q   <= '0;
			frame_q      <= '0;
		end else if (step) begin
			if (end_of_frame) begin
				byte_index_q <= '0;
				outer_hi_q   <= '0;
				frame_q      <= '0;
			end else begin
				byte_index_q <= index_nxt;
				outer_hi_q   <= outer_hi_nxt;
				frame_q      <= frame_nxt;
			end
		end
	end

endmodule

// ===== hdl/drfc_verdict.sv =====
// Frame verdict: IPv4 UDP to the BOOTP server port, length and mode checks.
`timescale 1ns / 1ps

module drfc_verdict #(
	parameter int INDEX_BITS = drfc_pkg::DRFC_INDEX_BITS
) (
	input  drfc_pkg::drfc_frame_t frame,
	input  logic [INDEX_BITS:0]   byte_count,
	input  logic                  client_mode,
	input  logic                  gateway_selected,
	output logic                  is_target
);

	localparam int CW = INDEX_BITS + 1;

	logic [CW-1:0] ip_start;
	logic [CW-1:0] ip_need;
	logic [CW-1:0] udp_need;

	// Minimum lengths for the IP and UDP headers
	assign ip_start = frame.vlan_tagged ? CW'(drfc_pkg::DRFC_IP_START_TAGGED)
	                                    : CW'(drfc_pkg::DRFC_IP_START_PLAIN);
	assign ip_need  = ip_start + CW'(drfc_pkg::DRFC_IP_MIN_HDR);
	assign udp_need = ip_start + CW'(frame.ip_header_bytes) + CW'(drfc_pkg::DRFC_UDP_HDR);

	assign is_target = client_mode && gateway_selected
	                   && byte_count >= CW'(drfc_pkg::DRFC_IP_START_PLAIN)
	                   && frame.inner_ethertype == drfc_pkg::DRFC_ETHTYPE_IPV4
	                   && byte_count >= ip_need
	                   && frame.ip_protocol == drfc_pkg::DRFC_PROTO_UDP
	                   && byte_count >= udp_need
	                   && frame.udp_dest_port == drfc_pkg::DRFC_BOOTP_PORT;

endmodule

// ===== tb/dhcp_request_frame_classifier_tb.sv =====
// Self-checking testbench for the DHCP request frame classifier: Ethernet frames in, one verdict out.
`timescale 1ns / 1ps

module dhcp_request_frame_classifier_tb;

	localparam int INDEX_MAX   = (1 << drfc_pkg::DRFC_INDEX_BITS) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 30;

	logic                                     clk          = 1'b0;
	logic                                     arst_n       = 1'b0;
	logic                                     cfg_we       = 1'b0;
	logic [drfc_pkg::DRFC_CFG_INDEX_BITS-1:0] cfg_index    = drfc_pkg::DRFC_REG_CLIENT_MODE;
	logic [drfc_pkg::DRFC_CFG_DATA_BITS-1:0]  cfg_data     = '0;
	logic                                     in_valid     = 1'b0;
	logic                                     in_stall;
	logic [7:0]                               frame_byte   = 8'h00;
	logic                                     end_of_frame = 1'b0;
	logic                                     out_valid;
	logic                                     out_stall    = 1'b0;
	logic                                     is_target;

	dhcp_request_frame_classifier DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_target    (is_target)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the configuration and of the per-frame header capture
	logic                                 client_mode_r;
	logic                                 gateway_sel_r;
	logic [drfc_pkg::DRFC_INDEX_BITS-1:0] byte_pos;
	logic [15:0]                          outer_type;
	logic                                 vlan_seen;
	logic [15:0]                          inner_type;
	logic [5:0]                           ip_hdr_len;
	logic [7:0]                           ip_proto;
	logic [15:0]                          udp_dport;

	logic       verdict_q[$];
	logic [7:0] frame_buf[$];
	logic       want_verdict;
	bit         idle_enable = 1'b1;
	int         mismatches  = 0;
	int         cycle_count = 0;

	task automatic clear_frame_state();
		byte_pos   = '0;
		outer_type = '0;
		vlan_seen  = 1'b0;
		inner_type = '0;
		ip_hdr_len = '0;
		ip_proto   = '0;
		udp_dport  = '0;
	endtask

	// Header tracking for one accepted byte; queues the verdict on the last byte
	task automatic track_byte(input logic [7:0] b, input logic eof);
		int   pos;
		int   ip_base;
		int   udp_base;
		int   count;
		logic hit;
		pos     = byte_pos;
		ip_base = vlan_seen ? drfc_pkg::DRFC_IP_START_TAGGED
			: drfc_pkg::DRFC_IP_START_PLAIN;
		if (pos == drfc_pkg::DRFC_POS_TYPE_HI) begin
			outer_type[15:8] = b;
		end else if (pos == drfc_pkg::DRFC_POS_TYPE_LO) begin
			outer_type[7:0] = b;
			vlan_seen = (outer_type == drfc_pkg::DRFC_ETHTYPE_VLAN);
			if (!vlan_seen)
				inner_type = outer_type;
		end else if (vlan_seen && pos == drfc_pkg::DRFC_POS_INNER_HI) begin
			inner_type[15:8] = b;
		end else if (vlan_seen && pos == drfc_pkg::DRFC_POS_INNER_LO) begin
			inner_type[7:0] = b;
		end
		if (pos >= drfc_pkg::DRFC_IP_START_PLAIN) begin
			if (pos == ip_base)
				ip_hdr_len = {b[3:0], 2'b00};
			if (pos == ip_base + drfc_pkg::DRFC_IP_PROTO_OFS)
				ip_proto = b;
			udp_base = ip_base + ip_hdr_len;
			if (pos > ip_base && pos == udp_base + drfc_pkg::DRFC_UDP_DPORT_OFS)
				udp_dport[15:8] = b;
			if (pos > ip_base && pos == udp_base + drfc_pkg::DRFC_UDP_DPORT_OFS + 1)
				udp_dport[7:0] = b;
		end
		// counter saturates on long frames
		if (pos < INDEX_MAX)
			byte_pos = byte_pos + 1'b1;
		if (eof) begin
			count    = pos + 1;
			ip_base  = vlan_seen ? drfc_pkg::DRFC_IP_START_TAGGED
				: drfc_pkg::DRFC_IP_START_PLAIN;
			udp_base = ip_base + ip_hdr_len;
			hit = client_mode_r && gateway_sel_r
				&& count >= drfc_pkg::DRFC_IP_START_PLAIN
				&& inner_type == drfc_pkg::DRFC_ETHTYPE_IPV4
				&& count >= ip_base + drfc_pkg::DRFC_IP_MIN_HDR
				&& ip_proto == drfc_pkg::DRFC_PROTO_UDP
				&& count >= udp_base + drfc_pkg::DRFC_UDP_HDR
				&& udp_dport == drfc_pkg::DRFC_BOOTP_PORT;
			verdict_q.push_back(hit);
			clear_frame_state();
		end
	endtask

	// Drive one byte request and wait until it is taken; called at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		frame_byte   <= b;
		end_of_frame <= eof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_byte(b, eof);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	function automatic void put_byte(input int at, input logic [7:0] v);
		if (at < frame_buf.size())
			frame_buf[at] = v;
	endfunction

	// Shortest length that still holds the IP and UDP headers
	function automatic int full_len(input bit vlan, input logic [3:0] ihl);
		int base;
		int need;
		base = vlan ? drfc_pkg::DRFC_IP_START_TAGGED : drfc_pkg::DRFC_IP_START_PLAIN;
		need = 4 * ihl + drfc_pkg::DRFC_UDP_HDR;
		if (need < drfc_pkg::DRFC_IP_MIN_HDR)
			need = drfc_pkg::DRFC_IP_MIN_HDR;
		return base + need;
	endfunction

	// Random payload with the header fields laid over it, truncated to len
	task automatic send_header_frame(input bit vlan, input logic [15:0] etype,
			input logic [3:0] ihl, input logic [7:0] proto, input logic [15:0] dport,
			input int len);
		int ip_base;
		int udp_base;
		frame_buf.delete();
		for (int i = 0; i < len; i++)
			frame_buf.push_back(8'($urandom));
		ip_base  = vlan ? drfc_pkg::DRFC_IP_START_TAGGED : drfc_pkg::DRFC_IP_START_PLAIN;
		udp_base = ip_base + 4 * ihl;
		if (vlan) begin
			put_byte(drfc_pkg::DRFC_POS_TYPE_HI, drfc_pkg::DRFC_ETHTYPE_VLAN[15:8]);
			put_byte(drfc_pkg::DRFC_POS_TYPE_LO, drfc_pkg::DRFC_ETHTYPE_VLAN[7:0]);
			put_byte(drfc_pkg::DRFC_POS_INNER_HI, etype[15:8]);
			put_byte(drfc_pkg::DRFC_POS_INNER_LO, etype[7:0]);
		end else begin
			put_byte(drfc_pkg::DRFC_POS_TYPE_HI, etype[15:8]);
			put_byte(drfc_pkg::DRFC_POS_TYPE_LO, etype[7:0]);
		end
		put_byte(ip_base, {4'h4, ihl});
		put_byte(ip_base + drfc_pkg::DRFC_IP_PROTO_OFS, proto);
		put_byte(udp_base + drfc_pkg::DRFC_UDP_DPORT_OFS, dport[15:8]);
		put_byte(udp_base + drfc_pkg::DRFC_UDP_DPORT_OFS + 1, dport[7:0]);
		send_frame();
	endtask

	task automatic send_flat_frame(input logic [7:0] v, input int len);
		frame_buf.delete();
		repeat (len)
			frame_buf.push_back(v);
		send_frame();
	endtask

	// Stop feeding and let every outstanding verdict come out
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_config(input logic client, input logic gateway);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_index <= drfc_pkg::DRFC_REG_CLIENT_MODE;
		cfg_data  <= client;
		@(negedge clk);
		cfg_index <= drfc_pkg::DRFC_REG_GATEWAY_SELECTED;
		cfg_data  <= gateway;
		@(negedge clk);
		cfg_we <= 1'b0;
		client_mode_r = client;
		gateway_sel_r = gateway;
	endtask

	// Mostly well-formed DHCP-like frames, some short, long or pure noise
	task automatic random_frame();
		bit          vlan;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] dport;
		int          full;
		int          len;
		int          pick;
		vlan   = ($urandom_range(0, 99) < 30);
		etype  = ($urandom_range(0, 99) < 85) ? drfc_pkg::DRFC_ETHTYPE_IPV4
			: (($urandom_range(0, 1) == 1) ? 16'h86DD : 16'($urandom));
		ihl    = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom);
		proto  = ($urandom_range(0, 99) < 85) ? drfc_pkg::DRFC_PROTO_UDP : 8'($urandom);
		dport  = ($urandom_range(0, 99) < 75) ? drfc_pkg::DRFC_BOOTP_PORT
			: (($urandom_range(0, 1) == 1) ? 16'd68 : 16'($urandom));
		full   = full_len(vlan, ihl);
		pick   = $urandom_range(0, 99);
		if (pick < 8) begin
			// noise
			send_header_frame(vlan, 16'($urandom), 4'($urandom), 8'($urandom),
				16'($urandom), $urandom_range(1, 90));
		end else begin
			if (pick < 70)
				len = full + $urandom_range(0, 12);
			else if (pick < 80)
				len = full;
			else if (pick < 95)
				len = $urandom_range(1, full - 1);
			else
				len = $urandom_range(INDEX_MAX, INDEX_MAX + 40);
			send_header_frame(vlan, etype, ihl, proto, dport, len);
		end
	endtask

	// Verdicts straight after reset, then with the classifier enabled
	task automatic test_reset_defaults();
		client_mode_r = 1'b0;
		gateway_sel_r = 1'b0;
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
		write_config(1'b1, 1'b1);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
	endtask

	// Each header field off by one thing, IHL corner values, short frames
	task automatic test_header_variants();
		send_header_frame(1, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(1, 4'd5));
		send_header_frame(0, 16'h86DD, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
		send_header_frame(1, 16'h86DD, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(1, 4'd5));
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, 8'd6,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			16'd68, full_len(0, 4'd5));
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			16'h4300, full_len(0, 4'd5));
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd15, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd15));
		// IHL below five puts the UDP header inside the IP header
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd0, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd0));
		send_header_frame(1, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd3, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(1, 4'd3));
		// frame ends one byte before the UDP header is complete
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5) - 1);
		// IP header cut short
		send_header_frame(1, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, 30);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, 1);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, 13);
		send_flat_frame(8'hFF, 20);
		send_flat_frame(8'h00, 20);
	endtask

	// Frames around and past the byte counter saturation point
	task automatic test_long_frames();
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, INDEX_MAX);
		send_header_frame(1, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, INDEX_MAX + 1);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd15, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, INDEX_MAX + 6);
	endtask

	// Verdict must drop when either enable bit is clear
	task automatic test_config_gating();
		write_config(1'b1, 1'b0);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
		write_config(1'b0, 1'b1);
		send_header_frame(0, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(0, 4'd5));
		write_config(1'b0, 1'b0);
		send_header_frame(1, drfc_pkg::DRFC_ETHTYPE_IPV4, 4'd5, drfc_pkg::DRFC_PROTO_UDP,
			drfc_pkg::DRFC_BOOTP_PORT, full_len(1, 4'd5));
		write_config(1'b1, 1'b1);
	endtask

	// Random traffic in four configuration phases; the third is a long run without idling
	task automatic test_random_traffic();
		int phase_bytes;
		int phase_target;
		for (int phase = 0; phase < 4; phase++) begin
			if ($urandom_range(0, 99) < 60)
				write_config(1'b1, 1'b1);
			else
				write_config(1'($urandom), 1'($urandom));
			idle_enable  = (phase != 2);
			phase_target = (phase == 2) ? 120 : 20;
			phase_bytes  = 0;
			while (phase_bytes < phase_target) begin
				random_frame();
				phase_bytes += frame_buf.size();
			end
		end
		idle_enable = 1'b1;
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		out_stall <= idle_enable && ($urandom_range(0, 99) < IDLE_PCT);

	// Verdict checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: verdict %b with no frame outstanding", $realtime, is_target);
			end else begin
				want_verdict = verdict_q.pop_front();
				if (is_target !== want_verdict) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: is_target expected %b got %b", $realtime,
							want_verdict, is_target);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clear_frame_state();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_header_variants();
		test_long_frames();
		test_config_gating();
		test_random_traffic();
		drain_pipeline();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== dhcp_request_frame_classifier.f =====
hdl/drfc_pkg.sv
hdl/drfc_fields.sv
hdl/drfc_verdict.sv
hdl/dhcp_request_frame_classifier.sv
tb/dhcp_request_frame_classifier_tb.sv
